// ===== src/pol_pkg.sv =====
// shared types and constants for the positional ordered list
package pol_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned STATUS_W = 2;

  // request codes; the unused code falls to the default arm
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_BACK  = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_DUMP      = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_MOVE,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_MOVE,
    S_DUMP
  } state_t;

endpackage

// ===== src/pol_ram.sv =====
// generic single write port ram with registered read
module pol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/positional_ordered_list.sv =====
// positional ordered list: top level with sequencer around one storage ram
//
// channel   ports                                        handshake
// request   in_mode, in_value, in_position               start & !busy
// result    out_value_res, out_count, out_status, out_last  out_valid, one cycle
//
// an error request gives its result in the cycle after acceptance, busy stays low
// insert at 0-based index i: busy while the elements from i up move, one ram
//   read then one ram write per moved element (single read and write port)
// delete at index i: elements above it move down; dump: one result per element
// results are registered and cannot be held off
// reset is synchronous, active low, and clears the state, element count and out_valid;
//   storage contents are never read above the count, so no clearing pass
module positional_ordered_list import pol_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  output logic [VALUE_W-1:0]  out_value_res,
  output logic [COUNT_W-1:0]  out_count,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last
);

  // address, count and compare widths
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  // storage ram port signals
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic accept;

  // result fields chosen by the sequencer
  logic               emit;
  logic [VALUE_W-1:0] emit_value;
  status_t            emit_status;
  logic               emit_last;

  // position compares, widened so count + 1 never wraps
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic          ins_pos_bad;
  logic          del_pos_bad;
  logic [AW-1:0] pos_idx;
  logic          is_full;
  logic          is_empty;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign pos_ext     = PW'(in_position);
  assign cnt_ext     = PW'(count_r);
  assign ins_pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext + PW'(1));
  assign del_pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign pos_idx     = AW'(pos_ext - PW'(1));
  assign is_full     = (count_r == CW'(CAPACITY));
  assign is_empty    = (count_r == '0);

  pol_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // sequencer: decode, shift loop, dump walk
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    ram_we      = 1'b0;
    ram_waddr   = ptr_r;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;
    emit        = 1'b0;
    emit_value  = '0;
    emit_status = STAT_OK;
    emit_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_mode))
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
              if (is_full) begin
                emit        = 1'b1;
                emit_status = STAT_FULL;
              end else if ((mode_t'(in_mode) == MODE_INS_POS) && ins_pos_bad) begin
                emit        = 1'b1;
                emit_status = STAT_INVALID;
              end else begin
                // shift target starts one past the tail
                if (mode_t'(in_mode) == MODE_INS_FRONT) begin
                  idx_nxt = '0;
                end else if (mode_t'(in_mode) == MODE_INS_BACK) begin
                  idx_nxt = AW'(count_r);
                end else begin
                  idx_nxt = pos_idx;
                end
                ptr_nxt   = AW'(count_r);
                val_nxt   = in_value;
                state_nxt = S_INS_CHK;
              end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
              if (is_empty) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else if ((mode_t'(in_mode) == MODE_DEL_POS) && del_pos_bad) begin
                emit        = 1'b1;
                emit_status = STAT_INVALID;
              end else begin
                // fetch the element that leaves
                if (mode_t'(in_mode) == MODE_DEL_FRONT) begin
                  idx_nxt = '0;
                end else if (mode_t'(in_mode) == MODE_DEL_BACK) begin
                  idx_nxt = AW'(count_r - CW'(1));
                end else begin
                  idx_nxt = pos_idx;
                end
                ram_raddr = idx_nxt;
                state_nxt = S_DEL_CAP;
              end
            end
            MODE_DUMP: begin
              if (is_empty) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                ram_raddr = '0;
                ptr_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              emit        = 1'b1;
              emit_status = STAT_INVALID;
            end
          endcase
        end
      end

      S_INS_CHK: begin
        if (ptr_r == idx_r) begin
          ram_we     = 1'b1;
          ram_waddr  = ptr_r;
          ram_wdata  = val_r;
          count_nxt  = count_r + CW'(1);
          emit       = 1'b1;
          emit_value = val_r;
          state_nxt  = S_IDLE;
        end else begin
          ram_raddr = ptr_r - AW'(1);
          state_nxt = S_INS_MOVE;
        end
      end

      S_INS_MOVE: begin
        // move the element below up by one
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r - AW'(1);
        state_nxt = S_INS_CHK;
      end

      S_DEL_CAP: begin
        val_nxt   = ram_rdata;
        ptr_nxt   = idx_r;
        state_nxt = S_DEL_CHK;
      end

      S_DEL_CHK: begin
        if (CW'(ptr_r) + CW'(1) == count_r) begin
          count_nxt  = count_r - CW'(1);
          emit       = 1'b1;
          emit_value = val_r;
          state_nxt  = S_IDLE;
        end else begin
          ram_raddr = ptr_r + AW'(1);
          state_nxt = S_DEL_MOVE;
        end
      end

      S_DEL_MOVE: begin
        // close the gap from above
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r + AW'(1);
        state_nxt = S_DEL_CHK;
      end

      S_DUMP: begin
        // one element per cycle, next read issued alongside
        emit       = 1'b1;
        emit_value = ram_rdata;
        emit_last  = (CW'(ptr_r) + CW'(1) == count_r);
        if (emit_last) begin
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = emit;
    out_value_nxt  = emit_value;
    out_count_nxt  = COUNT_W'(count_nxt);
    out_status_nxt = emit_status;
    out_last_nxt   = emit_last;
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_count     = out_count_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

// ===== src/pol_checker.sv =====
// port level checker for the positional ordered list, with its bind
module pol_checker import pol_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [VALUE_W-1:0]  out_value_res,
  input logic [COUNT_W-1:0]  out_count,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_last
);

  // an accepted request either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  // error results are single, carry a zero value
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_last && (out_value_res == '0)))
    else $error("error result not final or value nonzero");

  // dump results come back to back until the final one
  a_dump_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_valid && (out_count == $past(out_count))))
    else $error("dump burst broken");

  // full is only reported at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> (out_count == COUNT_W'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

bind positional_ordered_list pol_checker #(
  .CAPACITY (CAPACITY)
) u_pol_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_value_res (out_value_res),
  .out_count     (out_count),
  .out_status    (out_status),
  .out_last      (out_last)
);
